>>> sv/life_row_word_stepper_top_macros.svh
// ----------------------------------------------------------------------------
// life_row_word_stepper_top_macros.svh
// Assertion macros shared by the stepper's checker.
// ----------------------------------------------------------------------------
`ifndef LIFE_ROW_WORD_STEPPER_TOP_MACROS_SVH
`define LIFE_ROW_WORD_STEPPER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LRWS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lrws assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LRWS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lrws assertion failed");

`endif

>>> sv/lrws_pkg.sv
// ----------------------------------------------------------------------------
// lrws_pkg
// Types, constants and helpers for the Life row word stepper.
// ----------------------------------------------------------------------------
package lrws_pkg;

	localparam int unsigned CELLS_PER_WORD = 16;
	localparam int unsigned BORN_TOTAL     = 3;

	typedef logic [CELLS_PER_WORD-1:0] word_t;
	typedef logic [1:0]                colsum_t;   // 0..3 live cells in a column
	typedef colsum_t [CELLS_PER_WORD-1:0] colsum_word_t;
	typedef logic [3:0]                total_t;    // 0..9 over a 3x3 block

	localparam total_t BORN_SUM    = total_t'(BORN_TOTAL);
	localparam total_t SURVIVE_SUM = total_t'(BORN_TOTAL + 1);

	typedef struct packed {
		word_t above_cells;
		word_t middle_cells;
		word_t below_cells;
		logic  row_end;
	} item_t;

	typedef struct packed {
		word_t next_cells;
		logic  last_of_row;
	} result_t;

	function automatic colsum_t col_sum(input logic a, input logic m, input logic b);
		return colsum_t'({1'b0, a}) + colsum_t'({1'b0, m}) + colsum_t'({1'b0, b});
	endfunction

endpackage

>>> sv/lrws_lane.sv
// ----------------------------------------------------------------------------
// lrws_lane
// One cell of the word: 3x3 total and the B3/S23 rule.
// ----------------------------------------------------------------------------
module lrws_lane (
	input  lrws_pkg::colsum_t left_sum,
	input  lrws_pkg::colsum_t centre_sum,
	input  lrws_pkg::colsum_t right_sum,
	input  logic              alive,
	output logic              next_alive
);
	import lrws_pkg::*;

	total_t total;

	// total includes the cell itself, so survival is 3 or 4
	assign total = total_t'(left_sum) + total_t'(centre_sum) + total_t'(right_sum);
	assign next_alive = (total == BORN_SUM) || (alive && (total == SURVIVE_SUM));

endmodule

>>> sv/lrws_word.sv
// ----------------------------------------------------------------------------
// lrws_word
// Row of cell lanes over one word; merges lane bits into the next word.
// ----------------------------------------------------------------------------
module lrws_word (
	input  lrws_pkg::colsum_word_t sums,
	input  lrws_pkg::word_t        cells,
	input  lrws_pkg::colsum_t      left_sum,
	input  lrws_pkg::colsum_t      right_sum,
	output lrws_pkg::word_t        next_cells
);
	import lrws_pkg::*;

	word_t lane_bits;

	for (genvar i = 0; i < CELLS_PER_WORD; i++) begin : g_lane
		colsum_t l_sum;
		colsum_t r_sum;

		if (i == 0) begin : g_left_edge
			assign l_sum = left_sum;
		end else begin : g_left_in
			assign l_sum = sums[i-1];
		end

		if (i == CELLS_PER_WORD - 1) begin : g_right_edge
			assign r_sum = right_sum;
		end else begin : g_right_in
			assign r_sum = sums[i+1];
		end

		lrws_lane u_lane (
			.left_sum   (l_sum),
			.centre_sum (sums[i]),
			.right_sum  (r_sum),
			.alive      (cells[i]),
			.next_alive (lane_bits[i])
		);
	end

	assign next_cells = lane_bits;

endmodule

>>> sv/life_row_word_stepper_top.sv
// ----------------------------------------------------------------------------
// life_row_word_stepper_top
// One B3/S23 Life generation for a row streamed as packed 16-cell words.
//
//   channel   signals                               direction
//   item      item_valid / item_stall / item        in  (above, middle, below, row_end)
//   result    result_valid / result_stall / result  out (next_cells, last_of_row)
//
// One item transaction is accepted per cycle while item_stall is low. Each word's
// result needs the first column of the following word, so it is queued when that word
// arrives and shows on result once the results ahead of it are taken. A row end with a
// word pending queues two results, but a row's first word queues none, so with result
// never stalled the queue holds two or fewer and item never stalls, rows included.
// item_stall rises when the 4-entry queue holds 3 or more; arst_n clears both.
// ----------------------------------------------------------------------------
module life_row_word_stepper_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lrws_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output lrws_pkg::result_t result
);
	import lrws_pkg::*;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic [PTR_W-1:0] qptr_t;
	typedef logic [CNT_W-1:0] qcount_t;

	// pending word: the last accepted word still waiting on its right neighbor
	colsum_word_t pend_sums_q;
	word_t        pend_cells_q;
	logic         have_pend_q;
	colsum_t      left_sum_q;     // column just left of the pending word

	// result queue
	result_t queue_q [QUEUE_DEPTH];
	qptr_t   wr_ptr_q;
	qptr_t   rd_ptr_q;
	qcount_t count_q;

	colsum_word_t item_sums;
	colsum_t      left_next;
	word_t        pend_next_cells;   // result for the pending word
	word_t        item_next_cells;   // result for this word at a row end
	logic         accept;
	logic         pop;
	logic         push_pend;
	logic         push_item;
	qptr_t        item_slot;

	// column sums of the incoming word, one per lane
	always_comb begin
		for (int i = 0; i < CELLS_PER_WORD; i++) begin
			item_sums[i] = col_sum(item.above_cells[i], item.middle_cells[i],
				item.below_cells[i]);
		end
	end

	// pending word closes with the incoming word's first column on its right
	lrws_word u_pend_word (
		.sums       (pend_sums_q),
		.cells      (pend_cells_q),
		.left_sum   (left_sum_q),
		.right_sum  (item_sums[0]),
		.next_cells (pend_next_cells)
	);

	// once the pending word retires, its last column sits left of this word
	assign left_next = have_pend_q ? pend_sums_q[CELLS_PER_WORD-1] : left_sum_q;

	// row end: this word closes against a dead column
	lrws_word u_end_word (
		.sums       (item_sums),
		.cells      (item.middle_cells),
		.left_sum   (left_next),
		.right_sum  ('0),
		.next_cells (item_next_cells)
	);

	assign accept    = item_valid && !item_stall;
	assign pop       = result_valid && !result_stall;
	assign push_pend = accept && have_pend_q;
	assign push_item = accept && item.row_end;
	assign item_slot = push_pend ? qptr_t'(wr_ptr_q + qptr_t'(1)) : wr_ptr_q;

	// room for two pushes must always remain
	assign item_stall   = (count_q > qcount_t'(QUEUE_DEPTH - 2));
	assign result_valid = (count_q != '0);
	assign result       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_pend_q <= 1'b0;
			left_sum_q  <= '0;
		end else if (accept) begin
			have_pend_q <= !item.row_end;
			left_sum_q  <= item.row_end ? colsum_t'(0) : left_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_sums_q  <= item_sums;
			pend_cells_q <= item.middle_cells;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend) begin
			queue_q[wr_ptr_q] <= '{next_cells: pend_next_cells, last_of_row: 1'b0};
		end
		if (push_item) begin
			queue_q[item_slot] <= '{next_cells: item_next_cells, last_of_row: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + qptr_t'(push_pend) + qptr_t'(push_item);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + qptr_t'(1);
			end
			count_q <= count_q + qcount_t'(push_pend) + qcount_t'(push_item)
				- qcount_t'(pop);
		end
	end

endmodule

>>> sv/lrws_checker.sv
// ----------------------------------------------------------------------------
// lrws_checker
// Port-level checks on the stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "life_row_word_stepper_top_macros.svh"

module lrws_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input lrws_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_stall,
	input lrws_pkg::result_t result
);
	import lrws_pkg::*;

	// a stalled result stays put
	`LRWS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

	// a row end always leaves at least one result queued
	`LRWS_ASSERT_NEXT(a_row_end_result, item_valid && !item_stall && item.row_end, result_valid)

	// input only backs up behind queued results
	`LRWS_ASSERT_IMP(a_stall_has_results, item_stall, result_valid)

	// results only go away by being taken
	`LRWS_ASSERT_IMP(a_drop_on_take, $fell(result_valid), $past(!result_stall))

endmodule

bind life_row_word_stepper_top lrws_checker u_lrws_checker (.*);
